@@ src/aojm_pkg.sv @@
// package for the as-of join match engine
// types, codes and sizes shared by the interfaces and modules
package aojm_pkg;

   localparam int TABLE_ROWS = 1024;
   localparam int ADDR_W     = $clog2(TABLE_ROWS);
   localparam int COUNT_W    = $clog2(TABLE_ROWS + 1);
   localparam int KEY_W      = 64;
   localparam int STAMP_W    = 64;
   localparam int REF_W      = 16;
   localparam int LIMIT_W    = 63;
   localparam int ROW_W      = KEY_W + STAMP_W + REF_W;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_PROBE = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_LOADED    = 3'd0,
      ST_SKIP_NULL = 3'd1,
      ST_FULL      = 3'd2,
      ST_MATCHED   = 3'd3,
      ST_PADDED    = 3'd4,
      ST_NO_ROW    = 3'd5,
      ST_CLEARED   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      REG_COMPARE_MODE    = 3'd0,
      REG_LEFT_OUTER      = 3'd1,
      REG_KEYS_USED       = 3'd2,
      REG_LOOKBACK_ENABLE = 3'd3,
      REG_LOOKBACK_LIMIT  = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic               compare_mode;
      logic               keys_used;
      logic               lookback_enable;
      logic [LIMIT_W-1:0] lookback_limit;
   } scan_ctl_type;

   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [STAMP_W-1:0] stamp;
      logic [STAMP_W-1:0] diff;
      logic [REF_W-1:0]   row_ref;
   } cand_type;

endpackage

@@ src/aojm_req_if.sv @@
// request channel of the as-of join match engine
// valid/ready handshake with command payload, uses aojm_pkg
interface aojm_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        cmd;
   logic [aojm_pkg::KEY_W-1:0]        key;
   logic                              key_null;
   logic signed [aojm_pkg::STAMP_W-1:0] stamp;
   logic                              stamp_null;
   logic [aojm_pkg::REF_W-1:0]        row_ref;

   modport source (output valid, cmd, key, key_null, stamp, stamp_null, row_ref, input ready);
   modport sink (input valid, cmd, key, key_null, stamp, stamp_null, row_ref, output ready);
endinterface

@@ src/aojm_rsp_if.sv @@
// result channel of the as-of join match engine
// valid/ready handshake with result payload, uses aojm_pkg
interface aojm_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic                       emit_row;
   logic [aojm_pkg::REF_W-1:0] match_ref;
   logic                       match_found;

   modport source (output valid, status, emit_row, match_ref, match_found, input ready);
   modport sink (input valid, status, emit_row, match_ref, match_found, output ready);
endinterface

@@ src/as_of_join_match_engine_unit.sv @@
// top level of the as-of join match engine
// uses aojm_pkg, aojm_req_if, aojm_rsp_if, aojm_ram, aojm_filter_cell, aojm_best_cell
//
// usage: items arrive on req (cmd load, probe, clear) and each gives one
// item on rsp; cmd 3 is dropped with no result. rows live in a ram of
// TABLE_ROWS entries, written in load order.
// for load and clear the result sits in the output register
// on the next cycle. a probe reads the stored rows one per cycle through
// the ram read port into a chain of two cells (filter, best), and its
// result is loaded once the output register is free; a probe with a null
// stamp, a null key with keys on, or an empty table skips the scan.
// a new item is taken while a result waits, as long as the output register
// frees in the same cycle; a stalled receiver holds the result and blocks
// further items once the register is full.
// reset (synchronous) empties the table, loads register defaults and
// drops any pending result. no clearing pass is needed.
// configuration goes through the apb port at byte address 8*index, 64 bits.
module as_of_join_match_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   aojm_req_if.sink                          req,
   aojm_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [aojm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [aojm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [aojm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   aojm_pkg::fsm_type state_ff, state_in;

   logic                             compare_mode_ff, left_outer_ff, keys_used_ff;
   logic                             lookback_enable_ff;
   logic [aojm_pkg::LIMIT_W-1:0]     lookback_limit_ff;
   logic [aojm_pkg::COUNT_W-1:0]     row_count_ff, row_count_in;
   logic [aojm_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [aojm_pkg::KEY_W-1:0]       probe_key_ff;
   logic [aojm_pkg::STAMP_W-1:0]     probe_stamp_ff;
   logic                             rd_valid_ff, rd_valid_in;

   logic                             rsp_valid_ff;
   aojm_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                             rsp_emit_ff, rsp_emit_in;
   logic [aojm_pkg::REF_W-1:0]       rsp_ref_ff, rsp_ref_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic                             rsp_load;

   logic                             slot_free, req_fire, scan_ok, load_null;
   logic                             wr_en, best_clear, probe_take, csr_wr;
   logic [aojm_pkg::ROW_W-1:0]       rd_row;
   logic [2:0]                       csr_index;
   aojm_pkg::scan_ctl_type           ctl;
   aojm_pkg::cand_type               cand;
   logic                             have;
   logic [aojm_pkg::REF_W-1:0]       best_ref;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;
   assign load_null = req.stamp_null || (keys_used_ff && req.key_null);
   assign scan_ok   = !req.stamp_null && !(keys_used_ff && req.key_null);

   assign ctl.compare_mode    = compare_mode_ff;
   assign ctl.keys_used       = keys_used_ff;
   assign ctl.lookback_enable = lookback_enable_ff;
   assign ctl.lookback_limit  = lookback_limit_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aojm_pkg::FSM_IDLE: begin
            if (req_fire && aojm_pkg::cmd_type'(req.cmd) == aojm_pkg::CMD_PROBE) begin
               if (scan_ok && row_count_ff != '0) begin
                  state_in = aojm_pkg::FSM_SCAN;
               end else begin
                  state_in = aojm_pkg::FSM_DONE;
               end
            end
         end
         aojm_pkg::FSM_SCAN: begin
            if (cnt_ff == row_count_ff - 1'b1) begin
               state_in = aojm_pkg::FSM_DRAIN;
            end
         end
         aojm_pkg::FSM_DRAIN: begin
            if (!rd_valid_ff && !cand.valid) begin
               state_in = aojm_pkg::FSM_DONE;
            end
         end
         aojm_pkg::FSM_DONE: begin
            if (slot_free) begin
               state_in = aojm_pkg::FSM_IDLE;
            end
         end
         default: state_in = aojm_pkg::FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready     = 1'b0;
      wr_en         = 1'b0;
      best_clear    = 1'b0;
      probe_take    = 1'b0;
      rd_valid_in   = 1'b0;
      cnt_in        = cnt_ff;
      row_count_in  = row_count_ff;
      rsp_load      = 1'b0;
      rsp_status_in = aojm_pkg::ST_LOADED;
      rsp_emit_in   = 1'b0;
      rsp_ref_in    = '0;
      rsp_found_in  = 1'b0;
      case (state_ff)
         aojm_pkg::FSM_IDLE: begin
            req.ready = slot_free;
            if (req.valid && slot_free) begin
               case (aojm_pkg::cmd_type'(req.cmd))
                  aojm_pkg::CMD_LOAD: begin
                     rsp_load = 1'b1;
                     if (load_null) begin
                        rsp_status_in = aojm_pkg::ST_SKIP_NULL;
                     end else if (row_count_ff >= aojm_pkg::COUNT_W'(aojm_pkg::TABLE_ROWS)) begin
                        rsp_status_in = aojm_pkg::ST_FULL;
                     end else begin
                        rsp_status_in = aojm_pkg::ST_LOADED;
                        wr_en         = 1'b1;
                        row_count_in  = row_count_ff + 1'b1;
                     end
                  end
                  aojm_pkg::CMD_CLEAR: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = aojm_pkg::ST_CLEARED;
                     row_count_in  = '0;
                  end
                  aojm_pkg::CMD_PROBE: begin
                     probe_take = 1'b1;
                     best_clear = 1'b1;
                     cnt_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         aojm_pkg::FSM_SCAN: begin
            rd_valid_in = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
         end
         aojm_pkg::FSM_DRAIN: ;
         aojm_pkg::FSM_DONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (have) begin
                  rsp_status_in = aojm_pkg::ST_MATCHED;
                  rsp_emit_in   = 1'b1;
                  rsp_ref_in    = best_ref;
                  rsp_found_in  = 1'b1;
               end else if (left_outer_ff) begin
                  rsp_status_in = aojm_pkg::ST_PADDED;
                  rsp_emit_in   = 1'b1;
               end else begin
                  rsp_status_in = aojm_pkg::ST_NO_ROW;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aojm_pkg::FSM_IDLE;
         row_count_ff <= '0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_emit_ff   <= rsp_emit_in;
         rsp_ref_ff    <= rsp_ref_in;
         rsp_found_ff  <= rsp_found_in;
      end
      if (probe_take) begin
         probe_key_ff   <= req.key;
         probe_stamp_ff <= req.stamp;
      end
   end

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_mode_ff    <= 1'b0;
         left_outer_ff      <= 1'b0;
         keys_used_ff       <= 1'b1;
         lookback_enable_ff <= 1'b0;
         lookback_limit_ff  <= '0;
      end else if (csr_wr) begin
         case (aojm_pkg::reg_index_type'(csr_index))
            aojm_pkg::REG_COMPARE_MODE:    compare_mode_ff    <= csr_pwdata[0];
            aojm_pkg::REG_LEFT_OUTER:      left_outer_ff      <= csr_pwdata[0];
            aojm_pkg::REG_KEYS_USED:       keys_used_ff       <= csr_pwdata[0];
            aojm_pkg::REG_LOOKBACK_ENABLE: lookback_enable_ff <= csr_pwdata[0];
            aojm_pkg::REG_LOOKBACK_LIMIT:
               lookback_limit_ff <= csr_pwdata[aojm_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (aojm_pkg::reg_index_type'(csr_index))
         aojm_pkg::REG_COMPARE_MODE:    csr_prdata = {63'd0, compare_mode_ff};
         aojm_pkg::REG_LEFT_OUTER:      csr_prdata = {63'd0, left_outer_ff};
         aojm_pkg::REG_KEYS_USED:       csr_prdata = {63'd0, keys_used_ff};
         aojm_pkg::REG_LOOKBACK_ENABLE: csr_prdata = {63'd0, lookback_enable_ff};
         aojm_pkg::REG_LOOKBACK_LIMIT:  csr_prdata = {1'b0, lookback_limit_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   aojm_ram #(
      .WIDTH(aojm_pkg::ROW_W),
      .DEPTH(aojm_pkg::TABLE_ROWS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(row_count_ff[aojm_pkg::ADDR_W-1:0]),
      .wr_data({req.key, req.stamp, req.row_ref}),
      .rd_en  (rd_valid_in),
      .rd_addr(cnt_ff[aojm_pkg::ADDR_W-1:0]),
      .rd_data(rd_row)
   );

   aojm_filter_cell u_filter (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rd_valid_ff),
      .row        (rd_row),
      .probe_key  (probe_key_ff),
      .probe_stamp(probe_stamp_ff),
      .ctl        (ctl),
      .cand       (cand)
   );

   aojm_best_cell u_best (
      .clock   (clock),
      .reset   (reset),
      .clear   (best_clear),
      .cand    (cand),
      .ctl     (ctl),
      .have    (have),
      .best_ref(best_ref)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.emit_row    = rsp_emit_ff;
   assign rsp.match_ref   = rsp_ref_ff;
   assign rsp.match_found = rsp_found_ff;
endmodule

@@ src/aojm_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module aojm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/aojm_filter_cell.sv @@
// first scan cell: key match, direction test and distance of one stored row
// uses aojm_pkg, feeds aojm_best_cell
module aojm_filter_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [aojm_pkg::ROW_W-1:0]    row,
   input  logic [aojm_pkg::KEY_W-1:0]    probe_key,
   input  logic [aojm_pkg::STAMP_W-1:0]  probe_stamp,
   input  aojm_pkg::scan_ctl_type        ctl,
   output aojm_pkg::cand_type            cand
);
   aojm_pkg::cand_type cand_ff, cand_in;
   logic [aojm_pkg::KEY_W-1:0]   r_key;
   logic [aojm_pkg::STAMP_W-1:0] r_stamp;
   logic [aojm_pkg::REF_W-1:0]   r_ref;
   logic key_ok, dir_ok;

   assign {r_key, r_stamp, r_ref} = row;

   always_comb begin
      key_ok = !ctl.keys_used || (r_key == probe_key);
      if (!ctl.compare_mode) begin
         dir_ok       = $signed(r_stamp) <= $signed(probe_stamp);
         cand_in.diff = probe_stamp - r_stamp;
      end else begin
         dir_ok       = $signed(probe_stamp) <= $signed(r_stamp);
         cand_in.diff = r_stamp - probe_stamp;
      end
      cand_in.valid   = in_valid;
      cand_in.hit     = key_ok && dir_ok;
      cand_in.stamp   = r_stamp;
      cand_in.row_ref = r_ref;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.valid <= 1'b0;
      end else begin
         cand_ff.valid <= cand_in.valid;
      end
      cand_ff.hit     <= cand_in.hit;
      cand_ff.stamp   <= cand_in.stamp;
      cand_ff.diff    <= cand_in.diff;
      cand_ff.row_ref <= cand_in.row_ref;
   end

   assign cand = cand_ff;
endmodule

@@ src/aojm_best_cell.sv @@
// last scan cell: lookback test and running nearest row
// uses aojm_pkg, fed by aojm_filter_cell
module aojm_best_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  aojm_pkg::cand_type           cand,
   input  aojm_pkg::scan_ctl_type       ctl,
   output logic                         have,
   output logic [aojm_pkg::REF_W-1:0]   best_ref
);
   logic                         have_ff, have_in;
   logic [aojm_pkg::STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [aojm_pkg::REF_W-1:0]   best_ref_ff, best_ref_in;
   logic range_ok, better, take;

   always_comb begin
      range_ok = !ctl.lookback_enable || (cand.diff <= {1'b0, ctl.lookback_limit});
      if (!ctl.compare_mode) begin
         better = $signed(best_stamp_ff) < $signed(cand.stamp);
      end else begin
         better = $signed(cand.stamp) < $signed(best_stamp_ff);
      end
      take          = cand.valid && cand.hit && range_ok && (!have_ff || better);
      have_in       = have_ff;
      best_stamp_in = best_stamp_ff;
      best_ref_in   = best_ref_ff;
      if (clear) begin
         have_in = 1'b0;
      end else if (take) begin
         have_in       = 1'b1;
         best_stamp_in = cand.stamp;
         best_ref_in   = cand.row_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      best_stamp_ff <= best_stamp_in;
      best_ref_ff   <= best_ref_in;
   end

   assign have     = have_ff;
   assign best_ref = best_ref_ff;
endmodule

@@ verif/as_of_join_match_engine_unit_test.sv @@
`timescale 1ns / 1ps
// self-checking test of the as-of join match engine: directed and random load,
// probe and clear items against an in-bench predictor; uses aojm_pkg and both channel interfaces
module as_of_join_match_engine_unit_test;

   typedef struct packed {
      logic [2:0]                 status;
      logic                       emit_row;
      logic [aojm_pkg::REF_W-1:0] match_ref;
      logic                       match_found;
   } join_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [aojm_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [aojm_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [aojm_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   aojm_req_if req ();
   aojm_rsp_if rsp ();

   as_of_join_match_engine_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   logic [aojm_pkg::KEY_W-1:0]   row_keys [aojm_pkg::TABLE_ROWS];
   logic [aojm_pkg::STAMP_W-1:0] row_stamps [aojm_pkg::TABLE_ROWS];
   logic [aojm_pkg::REF_W-1:0]   row_refs [aojm_pkg::TABLE_ROWS];
   int unsigned                  rows_held;
   logic                         mode_ge, outer_join, key_match_on, lookback_on;
   logic [aojm_pkg::LIMIT_W-1:0] lookback_max;

   join_result_type pending_results [$];
   int  error_count = 0;
   int  results_seen = 0;
   int  idle_cycles = 0;
   bit  hold_off = 0;
   int  match_count = 0, pad_count = 0, full_count = 0;

   initial begin
      req.valid = 0; req.cmd = aojm_pkg::CMD_LOAD; req.key = '0; req.key_null = 0;
      req.stamp = '0; req.stamp_null = 0; req.row_ref = '0;
      rsp.ready = 0;
   end

   function automatic join_result_type predict_join(logic [1:0] cmd,
         logic [aojm_pkg::KEY_W-1:0] key, logic key_null,
         logic [aojm_pkg::STAMP_W-1:0] stamp, logic stamp_null,
         logic [aojm_pkg::REF_W-1:0] rr);
      join_result_type res;
      bit have;
      logic signed [aojm_pkg::STAMP_W-1:0] best, cand, probe;
      logic [aojm_pkg::STAMP_W-1:0] span;
      logic [aojm_pkg::REF_W-1:0] best_ref;
      res = '0;
      have = 0; best = '0; best_ref = '0; probe = stamp;
      case (cmd)
         aojm_pkg::CMD_LOAD: begin
            if (stamp_null || (key_match_on && key_null)) res.status = aojm_pkg::ST_SKIP_NULL;
            else if (rows_held >= aojm_pkg::TABLE_ROWS) res.status = aojm_pkg::ST_FULL;
            else begin
               row_keys[rows_held] = key;
               row_stamps[rows_held] = stamp;
               row_refs[rows_held] = rr;
               rows_held++;
               res.status = aojm_pkg::ST_LOADED;
            end
         end
         aojm_pkg::CMD_CLEAR: begin
            rows_held = 0;
            res.status = aojm_pkg::ST_CLEARED;
         end
         default: begin
            if (!stamp_null && !(key_match_on && key_null)) begin
               for (int i = 0; i < rows_held; i++) begin
                  cand = row_stamps[i];
                  if (key_match_on && row_keys[i] != key) continue;
                  if (!mode_ge) begin
                     if (cand > probe) continue;
                     span = probe - cand;
                  end else begin
                     if (probe > cand) continue;
                     span = cand - probe;
                  end
                  if (lookback_on && span > {1'b0, lookback_max}) continue;
                  if (!have || (!mode_ge ? best < cand : cand < best)) begin
                     have = 1; best = cand; best_ref = row_refs[i];
                  end
               end
            end
            if (have) res = '{aojm_pkg::ST_MATCHED, 1'b1, best_ref, 1'b1};
            else if (outer_join) begin
               res.status = aojm_pkg::ST_PADDED;
               res.emit_row = 1;
            end
            else res.status = aojm_pkg::ST_NO_ROW;
         end
      endcase
      return res;
   endfunction

   task automatic write_register(aojm_pkg::reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= aojm_pkg::CSR_ADDR_W'(8 * idx); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         aojm_pkg::REG_COMPARE_MODE:    mode_ge = value[0];
         aojm_pkg::REG_LEFT_OUTER:      outer_join = value[0];
         aojm_pkg::REG_KEYS_USED:       key_match_on = value[0];
         aojm_pkg::REG_LOOKBACK_ENABLE: lookback_on = value[0];
         default:                       lookback_max = value[aojm_pkg::LIMIT_W-1:0];
      endcase
   endtask

   task automatic set_join_mode(logic ge, logic outer, logic keys, logic lb_on,
         logic [62:0] lb);
      write_register(aojm_pkg::REG_COMPARE_MODE, ge);
      write_register(aojm_pkg::REG_LEFT_OUTER, outer);
      write_register(aojm_pkg::REG_KEYS_USED, keys);
      write_register(aojm_pkg::REG_LOOKBACK_ENABLE, lb_on);
      write_register(aojm_pkg::REG_LOOKBACK_LIMIT, {1'b0, lb});
   endtask

   task automatic send_item(logic [1:0] cmd, logic [aojm_pkg::KEY_W-1:0] key,
         logic key_null, logic [aojm_pkg::STAMP_W-1:0] stamp, logic stamp_null,
         logic [aojm_pkg::REF_W-1:0] rr, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1; req.cmd <= cmd; req.key <= key; req.key_null <= key_null;
      req.stamp <= stamp; req.stamp_null <= stamp_null; req.row_ref <= rr;
      do @(posedge clock); while (!req.ready);
      if (cmd != aojm_pkg::CMD_NONE) pending_results.insert(pending_results.size(),
         predict_join(cmd, key, key_null, stamp, stamp_null, rr));
   endtask

   task automatic wait_drained();
      req.valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (aojm_pkg::TABLE_ROWS + 8) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         join_result_type got, want;
         got = '{rsp.status, rsp.emit_row, rsp.match_ref, rsp.match_found};
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.status == aojm_pkg::ST_MATCHED) match_count++;
            if (got.status == aojm_pkg::ST_PADDED) pad_count++;
            if (got.status == aojm_pkg::ST_FULL) full_count++;
            if (got.status != want.status)
               begin $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               error_count++; end
            if (got.emit_row != want.emit_row)
               begin $display("%0t: emit_row exp %0d got %0d", $time, want.emit_row,
               got.emit_row); error_count++; end
            if (got.match_ref != want.match_ref)
               begin $display("%0t: match_ref exp %h got %h", $time, want.match_ref,
               got.match_ref); error_count++; end
            if (got.match_found != want.match_found)
               begin $display("%0t: match_found exp %0d got %0d", $time, want.match_found,
               got.match_found); error_count++; end
         end
      end
   end

   // receiver stalls
   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off) rsp.ready <= 0;
         else if (wait_left > 0) begin
            wait_left--; rsp.ready <= 0;
         end else begin
            rsp.ready <= 1;
            if (rsp.valid && rsp.ready) wait_left = $urandom_range(0, 3);
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_psel || reset
            || hold_off)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20 * aojm_pkg::TABLE_ROWS) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      set_join_mode(0, 1, 1, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 5, 0, 0, 0, 0);
      send_item(aojm_pkg::CMD_LOAD, 5, 0, 64'sh8000000000000000, 0, 16'h0001);
      send_item(aojm_pkg::CMD_LOAD, 5, 0, 64'sh7fffffffffffffff, 0, 16'hffff);
      send_item(aojm_pkg::CMD_LOAD, 5, 0, 10, 0, 16'h0010);
      send_item(aojm_pkg::CMD_LOAD, 5, 0, 10, 0, 16'h0011);
      send_item(aojm_pkg::CMD_LOAD, 7, 1, 3, 0, 16'h0077);
      send_item(aojm_pkg::CMD_LOAD, 7, 0, 3, 1, 16'h0078);
      send_item(aojm_pkg::CMD_LOAD, 64'hffffffffffffffff, 0, -20, 0, 16'h0099);
      send_item(aojm_pkg::CMD_PROBE, 5, 0, 10, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 5, 0, 64'sh8000000000000000, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 5, 0, 9, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 5, 0, 9, 1, 0);
      send_item(aojm_pkg::CMD_PROBE, 5, 1, 9, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 64'hffffffffffffffff, 0, 0, 0, 0);
      send_item(aojm_pkg::CMD_NONE, 5, 0, 9, 0, 0);
      wait_drained();
      set_join_mode(1, 0, 0, 1, 63'h7fffffffffffffff);
      send_item(aojm_pkg::CMD_PROBE, 0, 0, 9, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 0, 1, 64'sh8000000000000000, 0, 0);
      send_item(aojm_pkg::CMD_LOAD, 7, 1, 4, 0, 16'h0055);
      wait_drained();
      set_join_mode(0, 0, 0, 1, 0);
      send_item(aojm_pkg::CMD_PROBE, 0, 0, 10, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 0, 0, 11, 0, 0);
      send_item(aojm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
      send_item(aojm_pkg::CMD_PROBE, 0, 0, 11, 0, 0);
      wait_drained();
   endtask

   task automatic random_burst(int count);
      for (int n = 0; n < count; n++) begin
         int pick;
         logic [63:0] k, s;
         pick = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 3));
         s = ($urandom_range(0, 7) == 0) ? rand64() : 64'(int'($urandom_range(0, 200)) - 100);
         if (pick < 50)
            send_item(aojm_pkg::CMD_LOAD, k, $urandom_range(0, 9) == 0, s,
               $urandom_range(0, 9) == 0, 16'($urandom));
         else if (pick < 96)
            send_item(aojm_pkg::CMD_PROBE, k, $urandom_range(0, 9) == 0, s,
               $urandom_range(0, 9) == 0, 16'($urandom));
         else if (pick < 98) send_item(aojm_pkg::CMD_CLEAR, rand64(), 1'($urandom), rand64(),
            1'($urandom), 16'($urandom));
         else send_item(aojm_pkg::CMD_NONE, rand64(), 1'($urandom), rand64(), 1'($urandom),
            16'($urandom));
      end
   endtask

   task automatic test_random_modes();
      for (int phase = 0; phase < 8; phase++) begin
         set_join_mode(phase[0], phase[1], phase[2] | phase[0], 1'($urandom_range(0, 1)),
            (phase == 7) ? 63'h7fffffffffffffff : 63'($urandom_range(0, 80)));
         send_item(aojm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
         random_burst(63);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      set_join_mode(0, 1, 1, 0, 0);
      send_item(aojm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
      wait_drained();
      fork
         begin
            hold_off = 1;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end
         random_burst(40);
      join
      wait_drained();
   endtask

   initial begin
      rows_held = 0; mode_ge = 0; outer_join = 0; key_match_on = 1;
      lookback_on = 0; lookback_max = '0;
      repeat (12) @(posedge clock);
      reset <= 0;
      test_directed();
      test_random_modes();
      test_backpressure();
      wait_drained();
      $display("covered %0d results: %0d matched, %0d padded, %0d table full",
         results_seen, match_count, pad_count, full_count);
      $display("loads, probes, clears and dropped items under every register setting, "
         , "extreme lookback and a long receiver stall");
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
